>>> hdl/sida_pkg.sv
// shared types and constants for the signed integer to decimal text converter
`default_nettype none

package sida_pkg;

    // ascii codes of the emitted characters
    localparam logic [5:0] CHAR_PLUS  = 6'd43;
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // bcd digit width and the smallest digit that needs the add-3 correction
    localparam int unsigned DIGIT_W   = 4;
    localparam logic [3:0]  ADJ_LIMIT = 4'd5;
    localparam logic [3:0]  ADJ_ADD   = 4'd3;
    localparam logic [3:0]  DIGIT_MAX = 4'd9;

    // operation applied to every digit cell alike
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_op_t;

    // control handed from the sequencer to the cell row
    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_SIGN,
        ST_DIGITS
    } state_t;

endpackage

`default_nettype wire

>>> hdl/signed_int_to_decimal_ascii_unit.sv
// top level: sign handling, double-dabble digit row, leading-zero trim and character output
// conversion feeds one magnitude bit per cycle through the digit row; the trim then drops leading
//   zeros and the readout gives one character per cycle while the output is free; the next item
//   is taken while the last character waits
// reset: synchronous active-low aresetn returns the sequencer to idle and empties the output
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire signed [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [5:0]            m_character,
    output logic [3:0]            m_text_length,
    output logic                  m_last_char
);

    localparam int unsigned BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned LEN_W = CNT_W + 4;

    sida_pkg::state_t     state_reg, state_next;
    sida_pkg::cell_ctrl_t cell_ctrl;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic                  ovf_reg, ovf_next;
    logic [BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]      ndig_reg, ndig_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;

    logic                  m_valid_reg, m_valid_next;
    logic [5:0]            m_character_reg, m_character_next;
    logic [3:0]            m_text_length_reg, m_text_length_next;
    logic                  m_last_char_reg, m_last_char_next;

    logic                  s_accept;
    logic                  out_free;
    logic                  trim_go;
    logic                  out_load;
    logic [5:0]            out_char;
    logic                  out_last;
    logic [LEN_W-1:0]      len_full;
    logic [VALUE_BITS-1:0] value_mag;

    logic       carry_chain [0:MAX_DIGITS];
    logic [3:0] digit_chain [0:MAX_DIGITS];

    // row of digit cells, least significant at index 0
    assign carry_chain[0] = mag_reg[VALUE_BITS-1];
    assign digit_chain[0] = 4'd0;

    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
        sida_digit_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .bit_in    (carry_chain[i]),
            .digit_in  (digit_chain[i]),
            .digit_out (digit_chain[i+1]),
            .carry_out (carry_chain[i+1])
        );
    end

    // handshake helpers
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign trim_go  = !ovf_reg && (ndig_reg > CNT_W'(1))
                      && (digit_chain[MAX_DIGITS] == 4'd0);
    assign len_full = LEN_W'(ndig_reg) + LEN_W'(1);
    assign value_mag = s_value[VALUE_BITS-1] ? (~s_value + VALUE_BITS'(1)) : s_value;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sida_pkg::ST_IDLE: begin
                if (s_valid) state_next = sida_pkg::ST_CONVERT;
            end
            sida_pkg::ST_CONVERT: begin
                if (bit_cnt_reg == BIT_W'(0)) state_next = sida_pkg::ST_TRIM;
            end
            sida_pkg::ST_TRIM: begin
                if (!trim_go) state_next = sida_pkg::ST_SIGN;
            end
            sida_pkg::ST_SIGN: begin
                if (out_free) state_next = sida_pkg::ST_DIGITS;
            end
            sida_pkg::ST_DIGITS: begin
                if (out_free && rem_reg == CNT_W'(1)) state_next = sida_pkg::ST_IDLE;
            end
            default: state_next = sida_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready      = 1'b0;
        cell_ctrl.op = sida_pkg::CELL_HOLD;
        out_load     = 1'b0;
        out_char     = sida_pkg::CHAR_PLUS;
        out_last     = 1'b0;
        unique case (state_reg)
            sida_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cell_ctrl.op = sida_pkg::CELL_CLEAR;
            end
            sida_pkg::ST_CONVERT: begin
                cell_ctrl.op = sida_pkg::CELL_DABBLE;
            end
            sida_pkg::ST_TRIM: begin
                if (trim_go) cell_ctrl.op = sida_pkg::CELL_SHIFT;
            end
            sida_pkg::ST_SIGN: begin
                out_load = out_free;
                out_char = neg_reg ? sida_pkg::CHAR_MINUS : sida_pkg::CHAR_PLUS;
            end
            sida_pkg::ST_DIGITS: begin
                out_load = out_free;
                out_char = sida_pkg::CHAR_ZERO + {2'b00, digit_chain[MAX_DIGITS]};
                out_last = (rem_reg == CNT_W'(1));
                if (out_free) cell_ctrl.op = sida_pkg::CELL_SHIFT;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        mag_next           = mag_reg;
        neg_next           = neg_reg;
        ovf_next           = ovf_reg;
        bit_cnt_next       = bit_cnt_reg;
        ndig_next          = ndig_reg;
        rem_next           = rem_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_character_next   = m_character_reg;
        m_text_length_next = m_text_length_reg;
        m_last_char_next   = m_last_char_reg;

        if (s_accept) begin
            mag_next     = value_mag;
            neg_next     = s_value[VALUE_BITS-1];
            ovf_next     = 1'b0;
            bit_cnt_next = BIT_W'(VALUE_BITS - 1);
            ndig_next    = CNT_W'(MAX_DIGITS);
        end

        // one magnitude bit into the row per cycle, top carry marks lost digits
        if (state_reg == sida_pkg::ST_CONVERT) begin
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BIT_W'(1);
            ovf_next     = ovf_reg | carry_chain[MAX_DIGITS];
        end

        // drop one leading zero digit if trim_go, and set the readout countdown to the digit count
        if (state_reg == sida_pkg::ST_TRIM) begin
            if (trim_go) ndig_next = ndig_reg - CNT_W'(1);
            rem_next = ndig_reg;
        end

        if (state_reg == sida_pkg::ST_DIGITS && out_free) begin
            rem_next = rem_reg - CNT_W'(1);
        end

        if (out_load) begin
            m_valid_next       = 1'b1;
            m_character_next   = out_char;
            m_text_length_next = len_full[3:0];
            m_last_char_next   = out_last;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sida_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        mag_reg           <= mag_next;
        neg_reg           <= neg_next;
        ovf_reg           <= ovf_next;
        bit_cnt_reg       <= bit_cnt_next;
        ndig_reg          <= ndig_next;
        rem_reg           <= rem_next;
        m_character_reg   <= m_character_next;
        m_text_length_reg <= m_text_length_next;
        m_last_char_reg   <= m_last_char_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_character   = m_character_reg;
    assign m_text_length = m_text_length_reg;
    assign m_last_char   = m_last_char_reg;

    // remaining digit count stays within the trimmed length while reading out
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sida_pkg::ST_DIGITS |-> rem_reg != CNT_W'(0) && rem_reg <= ndig_reg)
        else $error("digit countdown out of range");

    // only decimal digits ever reach the top of the row at readout
    a_digit_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sida_pkg::ST_DIGITS |-> digit_chain[MAX_DIGITS] <= sida_pkg::DIGIT_MAX)
        else $error("non-decimal digit reached the output");

    // a character that is not the last one means the readout is still running
    a_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_last_char_reg |-> state_reg == sida_pkg::ST_DIGITS)
        else $error("run ended without a last character");

    // an accepted item always starts the conversion
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == sida_pkg::ST_CONVERT)
        else $error("accepted item did not start conversion");

endmodule

`default_nettype wire

>>> hdl/sida_digit_cell.sv
// one bcd digit cell of the double-dabble row, also used as a shift stage for readout
`default_nettype none

module sida_digit_cell (
    input  wire                 aclk,
    input  sida_pkg::cell_ctrl_t ctrl,
    input  wire                 bit_in,
    input  wire  [3:0]          digit_in,
    output logic [3:0]          digit_out,
    output logic                carry_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add-3 correction ahead of the left shift
    always_comb begin
        if (digit_reg >= sida_pkg::ADJ_LIMIT) begin
            adj = digit_reg + sida_pkg::ADJ_ADD;
        end else begin
            adj = digit_reg;
        end
    end

    assign carry_out = adj[3];
    assign digit_out = digit_reg;

    // next digit per row operation
    always_comb begin
        case (ctrl.op)
            sida_pkg::CELL_CLEAR:  digit_next = 4'd0;
            sida_pkg::CELL_DABBLE: digit_next = {adj[2:0], bit_in};
            sida_pkg::CELL_SHIFT:  digit_next = digit_in;
            default:               digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

>>> test/signed_int_to_decimal_ascii_unit_tb.sv
// testbench for the signed integer to decimal text converter: queued driver, checking monitor
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_unit_tb;

    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned RADIX      = 10;
    localparam int          N_RANDOM   = 400;
    localparam int          STALL_LIMIT = 3000;
    localparam int          LONG_HOLD   = 400;

    // one character of decimal text as the result port carries it
    typedef struct packed {
        logic [5:0] character;
        logic [3:0] text_length;
        logic       last_char;
    } text_char_t;

    // one input item, optionally held back until all owed text has come out
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        bit                    drain_first;
    } conv_job_t;

    // receiver ready patterns
    typedef enum int {
        SINK_FREE,
        SINK_RANDOM,
        SINK_SLOW
    } sink_mode_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [5:0]            m_character;
    logic [3:0]            m_text_length;
    logic                  m_last_char;

    conv_job_t  value_queue[$];
    text_char_t owed_chars[$];

    int          errors      = 0;
    int          items_sent  = 0;
    int          chars_seen  = 0;
    int          idle_cycles = 0;
    logic [11:0] lengths_seen = '0;
    bit          saw_min_neg = 1'b0;

    signed_int_to_decimal_ascii_unit #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_character(m_character),
        .m_text_length(m_text_length),
        .m_last_char(m_last_char)
    );

    // clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // work out the text for one value and queue it, sign first
    function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [3:0]            digits [MAX_DIGITS];
        int unsigned           ndig;
        logic                  negative;
        text_char_t            ch;
        negative  = value[VALUE_BITS-1];
        magnitude = negative ? (~value + 1'b1) : value;
        ndig      = 0;
        // digits come out least significant first
        do begin
            digits[ndig] = 4'(magnitude % RADIX);
            magnitude    = magnitude / RADIX;
            ndig++;
        end while (magnitude != 0 && ndig < MAX_DIGITS);
        for (int k = 0; k <= int'(ndig); k++) begin
            if (k == 0) begin
                ch.character = negative ? sida_pkg::CHAR_MINUS : sida_pkg::CHAR_PLUS;
            end else begin
                ch.character = sida_pkg::CHAR_ZERO + 6'(digits[ndig - k]);
            end
            ch.text_length = 4'(ndig + 1);
            ch.last_char   = (k == int'(ndig));
            owed_chars.push_back(ch);
        end
    endfunction

    function automatic void add_value(input logic [VALUE_BITS-1:0] value, input bit drain);
        conv_job_t job;
        job.value       = value;
        job.drain_first = drain;
        value_queue.push_back(job);
    endfunction

    // random value: mostly a chosen digit count so every text length turns up
    function automatic logic [VALUE_BITS-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        bit     neg;
        int     pick;
        pick = $urandom_range(9, 0);
        neg  = 1'($urandom_range(1, 0));
        if (pick < 3) begin
            return $urandom;
        end
        ndig = $urandom_range(10, 1);
        hi   = 1;
        for (int i = 0; i < ndig; i++) hi = hi * 10;
        lo = (ndig == 1) ? 0 : hi / 10;
        if (pick == 3) begin
            // around a power of ten
            mag = ($urandom_range(1, 0) != 0) ? lo : hi - 1;
            if (mag > 64'd2147483647) mag = 64'd2147483647;
        end else begin
            hi = hi - 1;
            if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
            mag = $urandom_range(32'(hi), 32'(lo));
        end
        return neg ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
    endfunction

    // sender: bursts of items with random gaps, one update per signal per edge
    always @(posedge aclk) begin : source_proc
        int   gap_left;
        int   burst_left;
        logic offering;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_value    <= '0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                queue_decimal_text(s_value);
                value_queue.delete(0);
                items_sent++;
                offering = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
                end
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (value_queue.size() != 0 &&
                             !(value_queue[0].drain_first && owed_chars.size() != 0)) begin
                    offering = 1'b1;
                    if (burst_left == 0) burst_left = $urandom_range(30, 1);
                end
                if (offering) s_value <= value_queue[0].value;
            end
            s_valid <= offering;
        end
    end

    // receiver: ready pattern of its own, plus one long hold-off
    always @(posedge aclk) begin : sink_proc
        sink_mode_t sink_mode;
        int         mode_left;
        int         hold_left;
        bit         long_hold_done;
        logic       ready_next;
        if (!aresetn) begin
            m_ready        <= 1'b0;
            sink_mode      = SINK_FREE;
            mode_left      = 0;
            hold_left      = 0;
            long_hold_done = 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (!long_hold_done && items_sent >= 150) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                ready_next     = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    sink_mode = sink_mode_t'($urandom_range(2, 0));
                    mode_left = $urandom_range(200, 20);
                end else begin
                    mode_left--;
                end
                case (sink_mode)
                    SINK_FREE:   ready_next = 1'b1;
                    SINK_RANDOM: ready_next = 1'($urandom_range(1, 0));
                    default:     ready_next = ($urandom_range(4, 0) == 0);
                endcase
            end
            m_ready <= ready_next;
        end
    end

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
        end
    endtask

    // monitor: compare each character with the oldest one owed, and watch for a hang
    always @(posedge aclk) begin : check_proc
        text_char_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d characters still owed",
                         $realtime, STALL_LIMIT, owed_chars.size());
                $display("DONE: errors detected");
                $finish;
            end
            if (m_valid && m_ready) begin
                chars_seen++;
                if (owed_chars.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected character, expected none, actual %0d",
                             $realtime, m_character);
                end else begin
                    want = owed_chars.pop_front();
                    check_field("character", want.character, m_character);
                    check_field("text_length", want.text_length, m_text_length);
                    check_field("last_char", want.last_char, m_last_char);
                    if (want.last_char) lengths_seen[want.text_length] = 1'b1;
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        // directed: extremes, zero, digit-count boundaries and alternating bit patterns
        add_value(32'd0, 1'b0);
        add_value(32'd1, 1'b0);
        add_value(-32'sd1, 1'b0);
        add_value(32'd9, 1'b0);
        add_value(32'd10, 1'b0);
        add_value(-32'sd10, 1'b0);
        add_value(32'd99, 1'b0);
        add_value(32'd100, 1'b0);
        add_value(-32'sd5, 1'b0);
        add_value(32'd2147483647, 1'b0);
        add_value(32'h8000_0000, 1'b0);
        add_value(32'h8000_0001, 1'b0);
        add_value(32'd1000000000, 1'b0);
        add_value(32'd999999999, 1'b0);
        add_value(-32'sd999999999, 1'b0);
        add_value(-32'sd1000000000, 1'b0);
        add_value(32'd123456789, 1'b0);
        add_value(32'h5555_5555, 1'b0);
        add_value(32'hAAAA_AAAA, 1'b0);
        add_value(32'd0, 1'b0);
        // random, with a few items that wait for the output to drain first
        for (int i = 0; i < N_RANDOM; i++) begin
            add_value(random_value(), (i % 97) == 0);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (value_queue.size() != 0 || s_valid || owed_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (80) @(posedge aclk);

        $display("converted %0d values into %0d characters; text lengths seen (bit per length): %b",
                 items_sent, chars_seen, lengths_seen[11:2]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> signed_int_to_decimal_ascii_unit.f
hdl/sida_pkg.sv
hdl/sida_digit_cell.sv
hdl/signed_int_to_decimal_ascii_unit.sv
test/signed_int_to_decimal_ascii_unit_tb.sv
